@@ rtl/cct_pkg.sv @@
// Package with the constants, types and calendar helpers of the calendar clock.
package cct_pkg;

    localparam int unsigned EPOCH_YEAR_VALUE = 1997;
    localparam int unsigned LAST_YEAR_VALUE  = 2082;

    localparam logic [11:0] EPOCH_YEAR = 12'(EPOCH_YEAR_VALUE);
    localparam logic [11:0] LAST_YEAR  = 12'(LAST_YEAR_VALUE);

    // Width of the clamped year offset from the base year.
    localparam int unsigned OFF_W = $clog2(LAST_YEAR_VALUE - EPOCH_YEAR_VALUE + 1);

    localparam logic [9:0] MILLI_STEP = 10'd10;
    localparam logic [9:0] MILLI_WRAP = 10'd1000;
    localparam logic [9:0] MILLI_MAX  = 10'd990;
    localparam logic [6:0] SEC_WRAP   = 7'd60;
    localparam logic [6:0] MIN_WRAP   = 7'd60;
    localparam logic [5:0] HOUR_WRAP  = 6'd24;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

    // Input transaction kinds.
    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_SET  = 1'b1
    } t_action;

    // Snapshot of the date and time after one transaction.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
    } t_snap;

    // Days in the year before the first of the given month (month 1..12).
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

@@ rtl/calendar_clock_tick_and_convert.sv @@
// Calendar clock top level: 10 ms tick counter, date load and timestamp conversion.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------------
//  input   | i_valid / o_ready   | i_action, i_set_*, i_next_*_in
//  output  | o_valid / i_ready   | o_packed_stamp, o_millis, o_seconds_since_base
//
// Every input transaction returns exactly one output transaction, after it has passed
// the stage 1 snapshot, the stage 2 registers and the output register. One transaction
// can be accepted every cycle while the output side is ready, because each stage of the
// three-stage conversion pipeline can hand its contents on in every cycle.
// Reset (i_rst_n low at a rising edge) empties the pipeline and loads the clock with
// 26 July 2013 00:00:00.000 and a next-day date of 27 July 2013.
// Each stage holds its contents while the stage after it is full and stalled, so a
// stall on the output backs up stage by stage and o_ready falls only when all three
// stages are full.
module calendar_clock_tick_and_convert
    import cct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [11:0] i_set_year,
    input  logic [3:0]  i_set_month,
    input  logic [4:0]  i_set_day,
    input  logic [4:0]  i_set_hour,
    input  logic [5:0]  i_set_minute,
    input  logic [5:0]  i_set_second,
    input  logic [11:0] i_next_year_in,
    input  logic [3:0]  i_next_month_in,
    input  logic [4:0]  i_next_day_in,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_packed_stamp,
    output logic [9:0]  o_millis,
    output logic [31:0] o_seconds_since_base
);

    // ------------------------------------------------------------------
    // Clock state. It is updated on every accepted transaction.
    // ------------------------------------------------------------------
    logic [9:0]  r_milli;
    logic [5:0]  r_second;
    logic [5:0]  r_minute;
    logic [4:0]  r_hour;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [11:0] r_next_year;
    logic [3:0]  r_next_month;
    logic [4:0]  r_next_day;

    logic [9:0]  n_milli;
    logic [5:0]  n_second;
    logic [5:0]  n_minute;
    logic [4:0]  n_hour;
    logic [11:0] n_year;
    logic [3:0]  n_month;
    logic [4:0]  n_day;
    logic [11:0] n_next_year;
    logic [3:0]  n_next_month;
    logic [4:0]  n_next_day;

    // Pipeline control.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic ok1;
    logic ok2;
    logic ok3;
    logic in_accept;

    // Stage 1: snapshot of the state after the transaction.
    t_snap r_s1;

    // Stage 2: stamp and millis final, day count and time of day ready to combine.
    logic [31:0] r_s2_stamp;
    logic [9:0]  r_s2_millis;
    logic [15:0] r_s2_days;
    logic [16:0] r_s2_tod;

    // The output register is the last stage; a stage loads when it is empty or when
    // the stage after it moves on in the same cycle.
    assign ok3       = !r_v3 || i_ready;
    assign ok2       = !r_v2 || ok3;
    assign ok1       = !r_v1 || ok2;
    assign o_ready   = ok1;
    assign in_accept = i_valid && ok1;
    assign o_valid   = r_v3;

    // ------------------------------------------------------------------
    // Next state: a set loads everything and clears the milliseconds; a tick
    // ripples its carry from milliseconds up to hours, and a midnight rollover
    // copies the stored next-day date into the current date.
    // ------------------------------------------------------------------
    always_comb begin
        logic [10:0] milli_sum;
        logic [6:0]  sec_sum;
        logic [6:0]  min_sum;
        logic [5:0]  hour_sum;

        milli_sum = {1'b0, r_milli} + {1'b0, MILLI_STEP};
        sec_sum   = {1'b0, r_second} + 7'd1;
        min_sum   = {1'b0, r_minute} + 7'd1;
        hour_sum  = {1'b0, r_hour} + 6'd1;

        n_milli      = r_milli;
        n_second     = r_second;
        n_minute     = r_minute;
        n_hour       = r_hour;
        n_year       = r_year;
        n_month      = r_month;
        n_day        = r_day;
        n_next_year  = r_next_year;
        n_next_month = r_next_month;
        n_next_day   = r_next_day;

        if (t_action'(i_action) == ACT_SET) begin
            n_milli      = '0;
            n_second     = i_set_second;
            n_minute     = i_set_minute;
            n_hour       = i_set_hour;
            n_year       = i_set_year;
            n_month      = i_set_month;
            n_day        = i_set_day;
            n_next_year  = i_next_year_in;
            n_next_month = i_next_month_in;
            n_next_day   = i_next_day_in;
        end else if (milli_sum < {1'b0, MILLI_WRAP}) begin
            n_milli = milli_sum[9:0];
        end else begin
            n_milli = '0;
            if (sec_sum < SEC_WRAP) begin
                n_second = sec_sum[5:0];
            end else begin
                n_second = '0;
                if (min_sum < MIN_WRAP) begin
                    n_minute = min_sum[5:0];
                end else begin
                    n_minute = '0;
                    if (hour_sum < HOUR_WRAP) begin
                        n_hour = hour_sum[4:0];
                    end else begin
                        n_hour  = '0;
                        n_year  = r_next_year;
                        n_month = r_next_month;
                        n_day   = r_next_day;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_milli      <= '0;
            r_second     <= '0;
            r_minute     <= '0;
            r_hour       <= '0;
            r_year       <= 12'd2013;
            r_month      <= 4'd7;
            r_day        <= 5'd26;
            r_next_year  <= 12'd2013;
            r_next_month <= 4'd7;
            r_next_day   <= 5'd27;
        end else if (in_accept) begin
            r_milli      <= n_milli;
            r_second     <= n_second;
            r_minute     <= n_minute;
            r_hour       <= n_hour;
            r_year       <= n_year;
            r_month      <= n_month;
            r_day        <= n_day;
            r_next_year  <= n_next_year;
            r_next_month <= n_next_month;
            r_next_day   <= n_next_day;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: clamp the year, then build the packed stamp, the day count
    // since the base year and the seconds within the day. A year divisible by four
    // is a leap year, so the leap days before the clamped year are offset / 4 and
    // the clamped year is a leap year when offset mod 4 is 3.
    // ------------------------------------------------------------------
    logic [OFF_W-1:0] s2_off;
    logic [3:0]       s2_month;
    logic [4:0]       s2_day;
    logic [10:0]      s2_hours;
    logic [15:0]      s2_days;
    logic [16:0]      s2_tod;

    always_comb begin
        logic [11:0] year_c;
        logic [11:0] off_full;

        if (r_s1.year < EPOCH_YEAR) begin
            year_c = EPOCH_YEAR;
        end else if (r_s1.year > LAST_YEAR) begin
            year_c = LAST_YEAR;
        end else begin
            year_c = r_s1.year;
        end
        off_full = year_c - EPOCH_YEAR;
        s2_off   = off_full[OFF_W-1:0];

        if (r_s1.month == 4'd0) begin
            s2_month = 4'd1;
        end else if (r_s1.month > MONTH_DEC) begin
            s2_month = MONTH_DEC;
        end else begin
            s2_month = r_s1.month;
        end
        s2_day = (r_s1.day == 5'd0) ? 5'd1 : r_s1.day;

        s2_hours = 11'(s2_off * HOURS_PER_DAY) + 11'(r_s1.hour);

        s2_days = 16'(s2_off * DAYS_PER_YEAR)
                + 16'(s2_off >> 2)
                + 16'(days_before_month(s2_month))
                + 16'((s2_off[1:0] == 2'd3) && (s2_month > MONTH_FEB))
                + 16'(s2_day - 5'd1);

        s2_tod = 17'(r_s1.hour * SECS_PER_HOUR)
               + 17'(r_s1.minute * SECS_PER_MIN)
               + 17'(r_s1.second);
    end

    // ------------------------------------------------------------------
    // Pipeline registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ok1) begin
                r_v1 <= i_valid;
            end
            if (ok2) begin
                r_v2 <= r_v1;
            end
            if (ok3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1.year   <= n_year;
            r_s1.month  <= n_month;
            r_s1.day    <= n_day;
            r_s1.hour   <= n_hour;
            r_s1.minute <= n_minute;
            r_s1.second <= n_second;
            r_s1.millis <= n_milli;
        end
        if (ok2 && r_v1) begin
            r_s2_stamp  <= {s2_hours, r_s1.day, r_s1.month, r_s1.minute, r_s1.second};
            r_s2_millis <= r_s1.millis;
            r_s2_days   <= s2_days;
            r_s2_tod    <= s2_tod;
        end
        if (ok3 && r_v2) begin
            o_packed_stamp       <= r_s2_stamp;
            o_millis             <= r_s2_millis;
            o_seconds_since_base <= 32'(r_s2_days * SECS_PER_DAY) + 32'(r_s2_tod);
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A set always leaves the millisecond counter at zero.
    a_set_clears_milli: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_action) |=> (r_milli == '0)
    ) else $error("millisecond counter not cleared by a set");

    // A tick that does not complete a second leaves the seconds untouched.
    a_tick_keeps_second: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_action && (r_milli != MILLI_MAX)) |=> $stable(r_second)
    ) else $error("seconds changed without a millisecond carry");

    // The millisecond counter never leaves its range.
    a_milli_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_millis <= MILLI_MAX)
    ) else $error("millisecond output out of range");

    // An accepted transaction always lands in the first stage.
    a_stage1_fill: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_v1
    ) else $error("accepted transaction lost before the first stage");

endmodule

@@ tb/sv/tb_calendar_clock_tick_and_convert.sv @@
// Self-checking testbench for the calendar clock: random set/tick traffic checked against a predictor.
module tb_calendar_clock_tick_and_convert
    import cct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------------------
    // Types and limits
    // ------------------------------------------------------------------------------------

    // One input transaction as the driver offers it. The drain flag asks the driver to hold
    // this transaction back until every earlier result has come out of the block.
    typedef struct {
        t_action     act;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [11:0] nyear;
        logic [3:0]  nmonth;
        logic [4:0]  nday;
        bit          drain;
    } t_clock_cmd;

    // One output transaction: the three values the block reports after an update.
    typedef struct {
        logic [31:0] stamp;
        logic [9:0]  millis;
        logic [31:0] secs;
    } t_clock_reading;

    // Receiver stall styles, drawn at random by the receiver.
    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_THREE_OF_FOUR,
        RX_TRICKLE
    } t_rx_style;

    localparam int unsigned TARGET_ITEMS   = 2000;
    localparam int unsigned HOLD_OFF_LEN   = 80;    // long receiver hold-off, in cycles
    localparam int unsigned TAIL_CYCLES    = 20;    // pipeline is three stages deep
    localparam int unsigned IDLE_LIMIT     = 4000;  // cycles with no transaction at all

    // Days before the first of each month in a common year, January first.
    localparam int unsigned MONTH_START [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    // ------------------------------------------------------------------------------------
    // Clock, reset and DUT connections
    // ------------------------------------------------------------------------------------

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_ready;
    logic        i_action        = 1'b0;
    logic [11:0] i_set_year      = '0;
    logic [3:0]  i_set_month     = '0;
    logic [4:0]  i_set_day       = '0;
    logic [4:0]  i_set_hour      = '0;
    logic [5:0]  i_set_minute    = '0;
    logic [5:0]  i_set_second    = '0;
    logic [11:0] i_next_year_in  = '0;
    logic [3:0]  i_next_month_in = '0;
    logic [4:0]  i_next_day_in   = '0;
    logic        o_valid;
    logic        i_ready         = 1'b0;
    logic [31:0] o_packed_stamp;
    logic [9:0]  o_millis;
    logic [31:0] o_seconds_since_base;

    always #5 i_clk = ~i_clk;

    calendar_clock_tick_and_convert u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_action             (i_action),
        .i_set_year           (i_set_year),
        .i_set_month          (i_set_month),
        .i_set_day            (i_set_day),
        .i_set_hour           (i_set_hour),
        .i_set_minute         (i_set_minute),
        .i_set_second         (i_set_second),
        .i_next_year_in       (i_next_year_in),
        .i_next_month_in      (i_next_month_in),
        .i_next_day_in        (i_next_day_in),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_packed_stamp       (o_packed_stamp),
        .o_millis             (o_millis),
        .o_seconds_since_base (o_seconds_since_base)
    );

    // ------------------------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------------------------

    t_clock_cmd     cmd_q[$];        // transactions still to be offered
    t_clock_reading reading_q[$];    // predicted readings, oldest first
    int unsigned    n_total    = 0;  // transactions put into cmd_q
    int unsigned    n_in       = 0;  // input transactions accepted (updated with <=)
    int unsigned    n_out      = 0;  // output transactions accepted (updated with <=)
    int unsigned    n_err      = 0;
    int unsigned    n_sets     = 0;
    int unsigned    n_ticks    = 0;
    int unsigned    n_midnight = 0;  // midnight rollovers seen by the predictor
    int unsigned    n_full     = 0;  // cycles in which the block refused an offered item
    int unsigned    idle_cnt   = 0;

    // Predictor copy of the clock state, at the block's widths.
    logic [9:0]  cal_ms;
    logic [5:0]  cal_sec;
    logic [5:0]  cal_min;
    logic [4:0]  cal_hour;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [11:0] nxt_year;
    logic [3:0]  nxt_month;
    logic [4:0]  nxt_day;

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    task automatic calendar_reset();
        cal_ms    = '0;
        cal_sec   = '0;
        cal_min   = '0;
        cal_hour  = '0;
        cal_year  = 12'd2013;
        cal_month = 4'd7;
        cal_day   = 5'd26;
        nxt_year  = 12'd2013;
        nxt_month = 4'd7;
        nxt_day   = 5'd27;
    endtask

    // Years outside the supported span are pinned to its ends for both outputs only.
    function automatic int unsigned clamp_year(input logic [11:0] yr);
        if (yr < EPOCH_YEAR_VALUE) return EPOCH_YEAR_VALUE;
        if (yr > LAST_YEAR_VALUE) return LAST_YEAR_VALUE;
        return int'(yr);
    endfunction

    // Applies one transaction to the predicted clock and returns the reading it produces.
    task automatic calendar_advance(input t_clock_cmd c, output t_clock_reading r);
        int unsigned ms_n;
        int unsigned sec_n;
        int unsigned min_n;
        int unsigned hour_n;
        int unsigned yr;
        int unsigned hours;
        int unsigned leap_days;
        int unsigned days;
        int unsigned mo;
        int unsigned dy;
        if (c.act == ACT_SET) begin
            cal_year  = c.year;
            cal_month = c.month;
            cal_day   = c.day;
            cal_hour  = c.hour;
            cal_min   = c.minute;
            cal_sec   = c.second;
            nxt_year  = c.nyear;
            nxt_month = c.nmonth;
            nxt_day   = c.nday;
            cal_ms    = '0;
        end else begin
            // Carries ripple upward; a field already out of range wraps to zero when it
            // is carried into, which is why the compares are >= and not ==.
            ms_n = cal_ms + 10;
            if (ms_n >= 1000) begin
                cal_ms = '0;
                sec_n  = cal_sec + 1;
                if (sec_n >= 60) begin
                    cal_sec = '0;
                    min_n   = cal_min + 1;
                    if (min_n >= 60) begin
                        cal_min = '0;
                        hour_n  = cal_hour + 1;
                        if (hour_n >= 24) begin
                            // Midnight: the date jumps to the stored next-day date.
                            cal_hour  = '0;
                            cal_year  = nxt_year;
                            cal_month = nxt_month;
                            cal_day   = nxt_day;
                            n_midnight++;
                        end else begin
                            cal_hour = hour_n[4:0];
                        end
                    end else begin
                        cal_min = min_n[5:0];
                    end
                end else begin
                    cal_sec = sec_n[5:0];
                end
            end else begin
                cal_ms = ms_n[9:0];
            end
        end

        yr    = clamp_year(cal_year);
        hours = (yr - EPOCH_YEAR_VALUE) * 24 + cal_hour;
        // Bits of the hour count that land above bit 31 are simply lost.
        r.stamp = 32'(cal_sec) | (32'(cal_min) << 6) | (32'(cal_month) << 12)
                | (32'(cal_day) << 16) | 32'(hours << 21);
        r.millis = cal_ms;

        // Leap days of the years from 2000 up to, but not including, the current one.
        leap_days = (yr >= 2000) ? (yr - 2000 + 3) / 4 : 0;
        days      = 365 * (yr - EPOCH_YEAR_VALUE) + leap_days;
        mo        = cal_month;
        if (mo < 1)  mo = 1;
        if (mo > 12) mo = 12;
        days += MONTH_START[mo - 1];
        if ((yr % 4) == 0 && mo > 2) days += 1;
        dy = cal_day;
        if (dy < 1) dy = 1;
        days += dy - 1;
        r.secs = 32'(days * 86400 + cal_hour * 3600 + cal_min * 60 + cal_sec);
    endtask

    // ------------------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------------------

    function automatic t_clock_cmd make_set(
        input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy,
        input logic [4:0] hr, input logic [5:0] mi, input logic [5:0] se,
        input logic [11:0] nyr, input logic [3:0] nmo, input logic [4:0] ndy
    );
        t_clock_cmd c;
        c.act    = ACT_SET;
        c.year   = yr;
        c.month  = mo;
        c.day    = dy;
        c.hour   = hr;
        c.minute = mi;
        c.second = se;
        c.nyear  = nyr;
        c.nmonth = nmo;
        c.nday   = ndy;
        c.drain  = 1'b0;
        return c;
    endfunction

    // A tick carries random junk in the load fields; the block must ignore it.
    function automatic t_clock_cmd make_tick();
        t_clock_cmd c;
        c = make_set(12'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                     6'($urandom), 6'($urandom), 12'($urandom), 4'($urandom),
                     5'($urandom));
        c.act = ACT_TICK;
        return c;
    endfunction

    function automatic logic [11:0] pick_year();
        case ($urandom_range(0, 9))
            0:       return 12'($urandom);                         // anything at all
            1:       return 12'($urandom_range(1990, 2090));       // around both ends
            default: return 12'($urandom_range(EPOCH_YEAR_VALUE, LAST_YEAR_VALUE));
        endcase
    endfunction

    function automatic logic [3:0] pick_month();
        return ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
    endfunction

    function automatic logic [4:0] pick_day();
        return ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 28));
    endfunction

    task automatic queue_cmd(input t_clock_cmd c);
        cmd_q.push_back(c);
        n_total++;
    endtask

    // A set close to a carry boundary followed by enough ticks to cross it. Most such
    // runs end in a midnight rollover; the out-of-range loads exercise the wrap rules.
    task automatic queue_rollover_run();
        t_clock_cmd  c;
        logic [4:0]  hr;
        logic [5:0]  mi;
        logic [5:0]  se;
        int unsigned n_tk;
        hr = ($urandom_range(0, 4) != 0) ? 5'd23 : 5'($urandom);
        mi = ($urandom_range(0, 4) != 0) ? 6'd59 : 6'($urandom_range(55, 63));
        if ($urandom_range(0, 3) != 0) begin
            se   = 6'd59;
            n_tk = $urandom_range(98, 140);
        end else begin
            se   = 6'($urandom_range(58, 63));
            n_tk = $urandom_range(98, 220);
        end
        c = make_set(pick_year(), pick_month(), pick_day(), hr, mi, se,
                     pick_year(), pick_month(), pick_day());
        queue_cmd(c);
        repeat (n_tk) queue_cmd(make_tick());
    endtask

    // Noise: a set with every field random, followed by a few ticks.
    task automatic queue_noise_run();
        t_clock_cmd c;
        c = make_tick();
        c.act = ACT_SET;
        queue_cmd(c);
        repeat ($urandom_range(0, 6)) queue_cmd(make_tick());
    endtask

    // ------------------------------------------------------------------------------------
    // Main sequence: fill the queue, release reset, wait for the end
    // ------------------------------------------------------------------------------------

    initial begin
        t_clock_cmd c;
        bit         mid_drain_done;
        mid_drain_done = 1'b0;

        // Directed part. The first tick shows the reset date and time.
        queue_cmd(make_tick());
        // All-zero load: year below the span, month zero and day zero.
        queue_cmd(make_set(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 12'd0, 4'd0, 5'd0));
        queue_cmd(make_tick());
        // All-ones load: year far above the span, month and time fields out of range.
        queue_cmd(make_set(12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F,
                           12'hFFF, 4'hF, 5'h1F));
        queue_cmd(make_tick());
        // The first instant of the base year reads as zero seconds.
        queue_cmd(make_set(12'(EPOCH_YEAR_VALUE), 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                           12'(EPOCH_YEAR_VALUE), 4'd1, 5'd2));
        // The last second of the last year.
        queue_cmd(make_set(12'(LAST_YEAR_VALUE), 4'd12, 5'd31, 5'd23, 6'd59, 6'd59,
                           12'(LAST_YEAR_VALUE), 4'd12, 5'd31));
        // Just outside each end of the span.
        queue_cmd(make_set(12'(EPOCH_YEAR_VALUE - 1), 4'd6, 5'd15, 5'd12, 6'd30, 6'd30,
                           12'd1997, 4'd6, 5'd16));
        queue_cmd(make_set(12'(LAST_YEAR_VALUE + 1), 4'd6, 5'd15, 5'd12, 6'd30, 6'd30,
                           12'd2083, 4'd6, 5'd16));
        // Leap-day handling around February and across leap and common years.
        queue_cmd(make_set(12'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0, 12'd2000, 4'd3, 5'd1));
        queue_cmd(make_set(12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 12'd2000, 4'd3, 5'd2));
        queue_cmd(make_set(12'd2001, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 12'd2001, 4'd3, 5'd2));
        queue_cmd(make_set(12'd2004, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 12'd2004, 4'd1, 5'd2));
        queue_cmd(make_set(12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59,
                           12'd2000, 4'd1, 5'd1));
        // Months past December count as December, a zero day as the first.
        queue_cmd(make_set(12'd2010, 4'd13, 5'd10, 5'd1, 6'd2, 6'd3, 12'd2010, 4'd14, 5'd0));
        queue_cmd(make_set(12'd2010, 4'd12, 5'd0, 5'd1, 6'd2, 6'd3, 12'd2010, 4'd12, 5'd1));
        // A tick whose load fields are all ones must not load anything.
        c = make_tick();
        c.year   = 12'hFFF;
        c.month  = 4'hF;
        c.day    = 5'h1F;
        c.hour   = 5'h1F;
        c.minute = 6'h3F;
        c.second = 6'h3F;
        queue_cmd(c);
        queue_cmd(make_tick());

        // The random part opens only once the directed results are all in.
        queue_rollover_run();
        cmd_q[n_total - ($urandom_range(0, 0) + 1)].drain = 1'b0;
        begin
            int unsigned first_rand;
            first_rand = 18;
            cmd_q[first_rand].drain = 1'b1;
        end

        while (n_total < TARGET_ITEMS) begin
            if ($urandom_range(0, 4) == 0) queue_noise_run();
            else                           queue_rollover_run();
            // Halfway through, the sender pauses once more until the block is empty.
            if (!mid_drain_done && n_total >= TARGET_ITEMS / 2) begin
                mid_drain_done = 1'b1;
                queue_noise_run();
                cmd_q[n_total - 1].drain = 1'b1;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transaction to go in and every reading to come out.
        do @(posedge i_clk);
        while (!(n_in == n_total && n_out == n_total));
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (reading_q.size() != 0) begin
            $display("%0t: %0d predicted readings never came out", $time, reading_q.size());
            n_err++;
        end

        $display("Run covered %0d loads and %0d ticks, %0d of them midnight rollovers.",
                 n_sets, n_ticks, n_midnight);
        $display("The input was held back in %0d cycles; %0d readings were checked.",
                 n_full, n_out);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Driver: offers queued transactions in bursts with random gaps between them
    // ------------------------------------------------------------------------------------

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        int unsigned in_after;
        t_clock_cmd  c;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else if (!i_valid || o_ready) begin
            // The slot is free after this edge: either nothing was offered or the
            // offered transaction has just been taken.
            in_after = n_in + ((i_valid && o_ready) ? 1 : 0);
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (cmd_q.size() != 0 && (!cmd_q[0].drain || in_after == n_out)) begin
                c = cmd_q.pop_front();
                i_valid         <= 1'b1;
                i_action        <= c.act;
                i_set_year      <= c.year;
                i_set_month     <= c.month;
                i_set_day       <= c.day;
                i_set_hour      <= c.hour;
                i_set_minute    <= c.minute;
                i_set_second    <= c.second;
                i_next_year_in  <= c.nyear;
                i_next_month_in <= c.nmonth;
                i_next_day_in   <= c.nday;
                if (burst_left <= 1) begin
                    // About a third of the bursts run straight into the next one.
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Receiver: changes its stall style now and then and holds off for a long stretch twice
    // ------------------------------------------------------------------------------------

    int unsigned rx_cycle  = 0;
    int unsigned hold_left = 0;
    t_rx_style   rx_style  = RX_OPEN;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            rx_cycle  = 0;
            hold_left = 0;
            rx_style  = RX_OPEN;
        end else begin
            rx_cycle++;
            // The long hold-offs fill all three pipeline stages so that o_ready drops
            // while the driver keeps offering.
            if (rx_cycle == 300 || rx_cycle == 2500) hold_left = HOLD_OFF_LEN;
            if (rx_cycle % 200 == 0) rx_style = t_rx_style'($urandom_range(0, 3));
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_OPEN:          i_ready <= 1'b1;
                    RX_COIN:          i_ready <= 1'($urandom_range(0, 1));
                    RX_THREE_OF_FOUR: i_ready <= (rx_cycle[1:0] != 2'd3);
                    default:          i_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Monitor: predicts on each accepted input, checks each accepted output, watchdog
    // ------------------------------------------------------------------------------------

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        n_err++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        t_clock_cmd     seen;
        t_clock_reading want;
        t_clock_reading got;
        if (!i_rst_n) begin
            calendar_reset();
            idle_cnt = 0;
        end else begin
            // Output side first: a result can never belong to an input taken this edge.
            if (o_valid && i_ready) begin
                got.stamp  = o_packed_stamp;
                got.millis = o_millis;
                got.secs   = o_seconds_since_base;
                if (reading_q.size() == 0) begin
                    n_err++;
                    $display("%0t: output transaction with no reading expected", $time);
                end else begin
                    want = reading_q.pop_front();
                    if (got.stamp !== want.stamp)
                        report_field("packed_stamp", want.stamp, got.stamp);
                    if (got.millis !== want.millis)
                        report_field("millis", 32'(want.millis), 32'(got.millis));
                    if (got.secs !== want.secs)
                        report_field("seconds_since_base", want.secs, got.secs);
                end
                n_out <= n_out + 1;
            end

            if (i_valid && !o_ready) n_full++;

            if (i_valid && o_ready) begin
                seen.act    = t_action'(i_action);
                seen.year   = i_set_year;
                seen.month  = i_set_month;
                seen.day    = i_set_day;
                seen.hour   = i_set_hour;
                seen.minute = i_set_minute;
                seen.second = i_set_second;
                seen.nyear  = i_next_year_in;
                seen.nmonth = i_next_month_in;
                seen.nday   = i_next_day_in;
                seen.drain  = 1'b0;
                if (seen.act == ACT_SET) n_sets++;
                else                     n_ticks++;
                calendar_advance(seen, want);
                reading_q.push_back(want);
                n_in <= n_in + 1;
            end

            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                idle_cnt = 0;
            end else begin
                idle_cnt++;
                if (idle_cnt >= IDLE_LIMIT) begin
                    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

endmodule
